### design/i2cm_pkg.sv
// Package for the I2C master byte engine: phase and command codes,
// configuration register struct and register index constants. No dependencies.
package i2cm_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_S0, PH_S1, PH_S2,
        PH_P0, PH_P1, PH_P2,
        PH_B0, PH_B1, PH_B2,
        PH_A0, PH_A1, PH_A2
    } t_phase;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_STOP  = 2'd1,
        FN_WRITE = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    typedef struct packed {
        logic [15:0] low_ticks;
        logic [15:0] high_ticks;
        logic [15:0] hold_ticks;
        logic        read_ack;
    } t_cfg;

    localparam logic [1:0] REG_LOW_TICKS  = 2'd0;
    localparam logic [1:0] REG_HIGH_TICKS = 2'd1;
    localparam logic [1:0] REG_HOLD_TICKS = 2'd2;
    localparam logic [1:0] REG_READ_ACK   = 2'd3;

endpackage

### design/i2cm_apb_regs.sv
// APB configuration registers of the I2C master byte engine.
// Depends on i2cm_pkg (t_cfg, register index constants).
module i2cm_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output i2cm_pkg::t_cfg                  o_cfg
);

    i2cm_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_ticks  <= 16'd8;
            r_cfg.high_ticks <= 16'd8;
            r_cfg.hold_ticks <= 16'd8;
            r_cfg.read_ack   <= 1'b1;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                i2cm_pkg::REG_LOW_TICKS:  r_cfg.low_ticks  <= pwdata[15:0];
                i2cm_pkg::REG_HIGH_TICKS: r_cfg.high_ticks <= pwdata[15:0];
                i2cm_pkg::REG_HOLD_TICKS: r_cfg.hold_ticks <= pwdata[15:0];
                i2cm_pkg::REG_READ_ACK:   r_cfg.read_ack   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            i2cm_pkg::REG_LOW_TICKS:  prdata = {16'd0, r_cfg.low_ticks};
            i2cm_pkg::REG_HIGH_TICKS: prdata = {16'd0, r_cfg.high_ticks};
            i2cm_pkg::REG_HOLD_TICKS: prdata = {16'd0, r_cfg.hold_ticks};
            i2cm_pkg::REG_READ_ACK:   prdata = {31'd0, r_cfg.read_ack};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

### design/i2c_master_byte_engine.sv
// I2C master byte engine top level: tick sequencer for SCL/SDA with an output register.
// Depends on i2cm_pkg and i2cm_apb_regs.
//
// channel   dir  handshake                 contents
// s_axis    in   tvalid/tready             one tick word: command offer and SDA sample
// m_axis    out  tvalid/tready             one line/status word per tick word
// apb       in   psel/penable, pready=1    low/high/hold ticks, read_ack
//
// One word enters per cycle unless input stalls; its result word is registered the same edge.
// The sequencer state advances only on accepted words; input stalls while the output
// register is full and not being taken. Synchronous active-low reset returns the bus to
// idle with SCL high and SDA released.
module i2c_master_byte_engine #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] cmd_valid, [8:1] wr_byte, [9] sda_in, [15:10] zero
    input  logic [i2cm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] func
    input  logic [i2cm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] scl, [1] sda_out, [2] sda_oe, [3] busy_res, [4] done_res,
    // [12:5] rd_byte, [13] ack_received, [15:14] zero
    output logic [i2cm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int VW = (TICK_COUNT_WIDTH < 16) ? TICK_COUNT_WIDTH : 16;
    localparam int DW = VW + 1;

    i2cm_pkg::t_cfg   w_cfg;
    i2cm_pkg::t_phase r_phase, n_phase;
    i2cm_pkg::t_func  r_cmd, n_cmd;
    logic [3:0]       r_bit, n_bit;
    logic [DW-1:0]    r_tick, n_tick;
    logic [7:0]       r_shift, n_shift;
    logic             r_ack, n_ack;
    logic [7:0]       r_rd, n_rd;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;
    logic             r_oe, n_oe;
    logic             r_out_valid;
    logic [i2cm_pkg::M_TDATA_W-1:0] r_out_data, n_out_data;

    logic          w_accept;
    logic          in_cv, in_sda;
    logic [7:0]    in_wr;
    i2cm_pkg::t_func in_fn;

    logic [VW-1:0] m_low, m_high, m_hold;
    logic [VW-1:0] tv_low, tv_high, tv_hold, hl_raw, tv_half;

    i2cm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_cv  = s_axis_tdata[0];
    assign in_wr  = s_axis_tdata[8:1];
    assign in_sda = s_axis_tdata[9];
    assign in_fn  = i2cm_pkg::t_func'(s_axis_tuser);

    // zero times count as one tick
    assign m_low   = w_cfg.low_ticks[VW-1:0];
    assign m_high  = w_cfg.high_ticks[VW-1:0];
    assign m_hold  = w_cfg.hold_ticks[VW-1:0];
    assign tv_low  = (m_low  == '0) ? VW'(1) : m_low;
    assign tv_high = (m_high == '0) ? VW'(1) : m_high;
    assign tv_hold = (m_hold == '0) ? VW'(1) : m_hold;
    assign hl_raw  = tv_low >> 1;
    assign tv_half = (hl_raw == '0) ? VW'(1) : hl_raw;

    always_comb begin
        i2cm_pkg::t_phase ph;
        logic             s, d, oe, rd, ackv, done, busy, out_sda;
        logic [DW-1:0]    dur, tick_inc;

        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_bit    = r_bit;
        n_tick   = r_tick;
        n_shift  = r_shift;
        n_ack    = r_ack;
        n_rd     = r_rd;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_oe     = r_oe;
        s        = r_scl;
        d        = r_sda;
        oe       = r_oe;
        done     = 1'b0;
        dur      = DW'(1);
        tick_inc = '0;

        if (r_phase == i2cm_pkg::PH_IDLE && in_cv) begin
            n_cmd   = in_fn;
            n_bit   = 4'd0;
            n_tick  = '0;
            n_shift = (in_fn == i2cm_pkg::FN_WRITE) ? in_wr : 8'd0;
            unique case (in_fn)
                i2cm_pkg::FN_START: n_phase = i2cm_pkg::PH_S0;
                i2cm_pkg::FN_STOP:  n_phase = i2cm_pkg::PH_P0;
                default:            n_phase = i2cm_pkg::PH_B0;
            endcase
        end

        ph   = n_phase;
        rd   = (n_cmd == i2cm_pkg::FN_READ);
        ackv = !w_cfg.read_ack;

        if (ph != i2cm_pkg::PH_IDLE) begin
            oe = 1'b1;
            unique case (ph)
                i2cm_pkg::PH_S0: begin s = 1'b1; d = 1'b1; dur = {1'b0, tv_high}; end
                i2cm_pkg::PH_S1: begin s = 1'b1; d = 1'b0; dur = {1'b0, tv_hold}; end
                i2cm_pkg::PH_S2: begin s = 1'b0; d = 1'b0; dur = {1'b0, tv_low}; end
                i2cm_pkg::PH_P0: begin s = 1'b0; d = 1'b0; dur = {tv_low, 1'b0}; end
                i2cm_pkg::PH_P1: begin s = 1'b1; d = 1'b0; dur = {tv_high, 1'b0}; end
                i2cm_pkg::PH_P2: begin s = 1'b1; d = 1'b1; dur = {1'b0, tv_hold}; end
                i2cm_pkg::PH_B0: begin
                    s = 1'b0; d = n_shift[7]; oe = !rd; dur = {1'b0, tv_half};
                end
                i2cm_pkg::PH_B1: begin
                    s = 1'b1; d = n_shift[7]; oe = !rd; dur = {1'b0, tv_high};
                end
                i2cm_pkg::PH_B2: begin
                    s = 1'b0; d = n_shift[7]; oe = !rd; dur = {1'b0, tv_half};
                end
                i2cm_pkg::PH_A0: begin s = 1'b0; d = rd & ackv; dur = {1'b0, tv_half}; end
                i2cm_pkg::PH_A1: begin
                    s = 1'b1; d = rd & ackv; oe = rd; dur = {1'b0, tv_high};
                end
                default: begin s = 1'b0; d = rd & ackv; dur = {1'b0, tv_half}; end
            endcase
            n_scl = s;
            n_sda = d;
            n_oe  = oe;

            tick_inc = n_tick + DW'(1);
            if (tick_inc >= dur) begin
                n_tick = '0;
                unique case (ph)
                    i2cm_pkg::PH_S0: n_phase = i2cm_pkg::PH_S1;
                    i2cm_pkg::PH_S1: n_phase = i2cm_pkg::PH_S2;
                    i2cm_pkg::PH_S2: begin n_phase = i2cm_pkg::PH_IDLE; done = 1'b1; end
                    i2cm_pkg::PH_P0: n_phase = i2cm_pkg::PH_P1;
                    i2cm_pkg::PH_P1: n_phase = i2cm_pkg::PH_P2;
                    i2cm_pkg::PH_P2: begin n_phase = i2cm_pkg::PH_IDLE; done = 1'b1; end
                    i2cm_pkg::PH_B0: n_phase = i2cm_pkg::PH_B1;
                    i2cm_pkg::PH_B1: begin
                        if (rd) n_shift = {n_shift[6:0], in_sda};
                        n_phase = i2cm_pkg::PH_B2;
                    end
                    i2cm_pkg::PH_B2: begin
                        if (!rd) n_shift = {n_shift[6:0], 1'b0};
                        n_bit   = n_bit + 4'd1;
                        n_phase = (n_bit >= 4'd8) ? i2cm_pkg::PH_A0 : i2cm_pkg::PH_B0;
                    end
                    i2cm_pkg::PH_A0: n_phase = i2cm_pkg::PH_A1;
                    i2cm_pkg::PH_A1: begin
                        if (!rd) n_ack = !in_sda;
                        n_phase = i2cm_pkg::PH_A2;
                    end
                    default: begin
                        if (rd) n_rd = n_shift;
                        n_phase = i2cm_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                endcase
            end else begin
                n_tick = tick_inc;
            end

            // bus released after a stop
            if (done && n_cmd == i2cm_pkg::FN_STOP) begin
                n_oe  = 1'b0;
                n_sda = 1'b1;
            end
        end

        out_sda    = oe ? d : 1'b1;
        busy       = (n_phase != i2cm_pkg::PH_IDLE);
        n_out_data = {2'b00, n_ack, n_rd, done, busy, oe, out_sda, s};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cm_pkg::PH_IDLE;
            r_cmd       <= i2cm_pkg::FN_START;
            r_bit       <= 4'd0;
            r_tick      <= '0;
            r_shift     <= 8'd0;
            r_ack       <= 1'b0;
            r_rd        <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_oe        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_bit   <= n_bit;
                r_tick  <= n_tick;
                r_shift <= n_shift;
                r_ack   <= n_ack;
                r_rd    <= n_rd;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_oe    <= n_oe;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

### tb/i2c_master_byte_engine_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_byte_engine: streams tick words with random gaps,
// predicts each line/status word with a behavioral bus sequencer and compares field by field.
// Depends on i2cm_pkg and the i2c_master_byte_engine RTL.
module i2c_master_byte_engine_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic            sda_in;
        logic [7:0]      wr_byte;
        logic            cmd_valid;
        i2cm_pkg::t_func func;
    } t_tick_word;

    typedef struct packed {
        logic [1:0] pad;
        logic       ack_received;
        logic [7:0] rd_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_oe;
        logic       sda_out;
        logic       scl;
    } t_line_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [i2cm_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [i2cm_pkg::S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [i2cm_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [i2cm_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    i2c_master_byte_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bus sequencer shadow
    i2cm_pkg::t_cfg   cfg = '{low_ticks: 16'd8, high_ticks: 16'd8,
                              hold_ticks: 16'd8, read_ack: 1'b1};
    i2cm_pkg::t_phase bus_phase = i2cm_pkg::PH_IDLE;
    i2cm_pkg::t_func  bus_cmd = i2cm_pkg::FN_START;
    logic [3:0]       bus_bits = '0;
    logic [17:0]      bus_ticks = '0;
    logic [7:0]       bus_shift = '0;
    logic [7:0]       bus_rd_byte = '0;
    logic             bus_ack = 1'b0;
    logic             bus_scl = 1'b1;
    logic             bus_sda = 1'b1;
    logic             bus_oe = 1'b0;

    function automatic logic [17:0] span(input logic [15:0] r);
        return (r == '0) ? 18'd1 : {2'b00, r};
    endfunction

    function automatic t_line_word step_bus(input t_tick_word t);
        t_line_word  w;
        logic [17:0] dur;
        logic [17:0] half;
        logic        s, d, oe, rd, ackv, done;
        w = '0;
        done = 1'b0;
        if (bus_phase == i2cm_pkg::PH_IDLE && t.cmd_valid) begin
            bus_cmd = t.func;
            bus_bits = '0;
            bus_ticks = '0;
            bus_shift = (t.func == i2cm_pkg::FN_WRITE) ? t.wr_byte : 8'h00;
            case (t.func)
                i2cm_pkg::FN_START: bus_phase = i2cm_pkg::PH_S0;
                i2cm_pkg::FN_STOP:  bus_phase = i2cm_pkg::PH_P0;
                default:            bus_phase = i2cm_pkg::PH_B0;
            endcase
        end
        if (bus_phase != i2cm_pkg::PH_IDLE) begin
            rd = (bus_cmd == i2cm_pkg::FN_READ);
            ackv = ~cfg.read_ack;
            half = span(cfg.low_ticks) >> 1;
            if (half == '0)
                half = 18'd1;
            s = 1'b0;
            d = 1'b0;
            oe = 1'b1;
            case (bus_phase)
                i2cm_pkg::PH_S0: begin
                    s = 1'b1; d = 1'b1; dur = span(cfg.high_ticks);
                end
                i2cm_pkg::PH_S1: begin s = 1'b1; dur = span(cfg.hold_ticks); end
                i2cm_pkg::PH_S2: dur = span(cfg.low_ticks);
                i2cm_pkg::PH_P0: dur = span(cfg.low_ticks) << 1;
                i2cm_pkg::PH_P1: begin s = 1'b1; dur = span(cfg.high_ticks) << 1; end
                i2cm_pkg::PH_P2: begin
                    s = 1'b1; d = 1'b1; dur = span(cfg.hold_ticks);
                end
                i2cm_pkg::PH_B0, i2cm_pkg::PH_B2: begin
                    d = bus_shift[7]; oe = ~rd; dur = half;
                end
                i2cm_pkg::PH_B1: begin
                    s = 1'b1; d = bus_shift[7]; oe = ~rd; dur = span(cfg.high_ticks);
                end
                i2cm_pkg::PH_A1: begin
                    s = 1'b1; d = rd & ackv; oe = rd; dur = span(cfg.high_ticks);
                end
                default: begin d = rd & ackv; dur = half; end
            endcase
            bus_scl = s;
            bus_sda = d;
            bus_oe = oe;
            bus_ticks = bus_ticks + 18'd1;
            if (bus_ticks >= dur) begin
                bus_ticks = '0;
                case (bus_phase)
                    i2cm_pkg::PH_S0: bus_phase = i2cm_pkg::PH_S1;
                    i2cm_pkg::PH_S1: bus_phase = i2cm_pkg::PH_S2;
                    i2cm_pkg::PH_P0: bus_phase = i2cm_pkg::PH_P1;
                    i2cm_pkg::PH_P1: bus_phase = i2cm_pkg::PH_P2;
                    i2cm_pkg::PH_P2: begin
                        bus_phase = i2cm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                    i2cm_pkg::PH_B0: bus_phase = i2cm_pkg::PH_B1;
                    i2cm_pkg::PH_B1: begin
                        if (rd)
                            bus_shift = {bus_shift[6:0], t.sda_in};
                        bus_phase = i2cm_pkg::PH_B2;
                    end
                    i2cm_pkg::PH_B2: begin
                        if (!rd)
                            bus_shift = {bus_shift[6:0], 1'b0};
                        bus_bits = bus_bits + 4'd1;
                        bus_phase = (bus_bits >= 4'd8) ? i2cm_pkg::PH_A0 : i2cm_pkg::PH_B0;
                    end
                    i2cm_pkg::PH_A0: bus_phase = i2cm_pkg::PH_A1;
                    i2cm_pkg::PH_A1: begin
                        if (!rd)
                            bus_ack = ~t.sda_in;
                        bus_phase = i2cm_pkg::PH_A2;
                    end
                    default: begin
                        if (rd)
                            bus_rd_byte = bus_shift;
                        bus_phase = i2cm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                endcase
            end
            w.scl = s;
            w.sda_out = oe ? d : 1'b1;
            w.sda_oe = oe;
            // stop leaves SDA released
            if (done && bus_cmd == i2cm_pkg::FN_STOP) begin
                bus_oe = 1'b0;
                bus_sda = 1'b1;
            end
        end else begin
            w.scl = bus_scl;
            w.sda_out = bus_oe ? bus_sda : 1'b1;
            w.sda_oe = bus_oe;
        end
        w.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
        w.done_res = done;
        w.rd_byte = bus_rd_byte;
        w.ack_received = bus_ack;
        return w;
    endfunction

    function automatic string show(input t_line_word w);
        return $sformatf("scl=%b sda=%b oe=%b busy=%b done=%b rd=%h ack=%b pad=%b",
                         w.scl, w.sda_out, w.sda_oe, w.busy_res, w.done_res, w.rd_byte,
                         w.ack_received, w.pad);
    endfunction

    t_tick_word pending_ticks[$];
    t_line_word line_words_due[$];
    t_tick_word offered;
    int         send_gap = 0;
    logic       sender_hold = 1'b0;
    logic       quiet_run = 1'b0;

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                line_words_due.push_back(step_bus(offered));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0 && !sender_hold) begin
                    offered = pending_ticks.pop_front();
                    s_axis_tdata <= {6'b0, offered.sda_in, offered.wr_byte, offered.cmd_valid};
                    s_axis_tuser <= offered.func;
                    s_axis_tvalid <= 1'b1;
                    send_gap <= quiet_run ? 0 : $urandom_range(0, 3);
                end else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    t_line_word got_word;
    t_line_word due_word;
    int         recv_gap = 0;
    int         recv_draw;
    int         stall_left = 0;
    int         stalls_asked = 0;
    int         stalls_done = 0;
    int         error_count = 0;

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_word = t_line_word'(m_axis_tdata);
                if (line_words_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected word: %s", show(got_word));
                end else begin
                    due_word = line_words_due.pop_front();
                    if (got_word.scl !== due_word.scl || got_word.sda_out !== due_word.sda_out ||
                        got_word.sda_oe !== due_word.sda_oe ||
                        got_word.busy_res !== due_word.busy_res ||
                        got_word.done_res !== due_word.done_res ||
                        got_word.rd_byte !== due_word.rd_byte ||
                        got_word.ack_received !== due_word.ack_received ||
                        got_word.pad !== due_word.pad) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch at %0t: expected %s, got %s",
                                     $realtime, show(due_word), show(got_word));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (stalls_done != stalls_asked) begin
                stall_left <= LONG_STALL;
                stalls_done <= stalls_done + 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                recv_draw = quiet_run ? 0 : $urandom_range(0, 3);
                m_axis_tready <= (recv_draw == 0);
                recv_gap <= (recv_draw > 0) ? recv_draw - 1 : 0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else
                m_axis_tready <= 1'b1;
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // sda_mode: 0 or 1 holds SDA at that level, 2 draws it per tick
    function automatic t_tick_word rand_tick(input int cmd_pct, input int sda_mode);
        t_tick_word t;
        t.cmd_valid = ($urandom_range(0, 99) < cmd_pct);
        t.func = i2cm_pkg::t_func'($urandom_range(0, 3));
        t.wr_byte = 8'($urandom);
        t.sda_in = (sda_mode == 2) ? 1'($urandom) : sda_mode[0];
        return t;
    endfunction

    // feed idle ticks until the sequencer is back in idle
    task automatic settle_bus(input int sda_mode);
        forever begin
            @(negedge i_clk);
            if (bus_phase == i2cm_pkg::PH_IDLE && pending_ticks.size() == 0 && !s_axis_tvalid)
                break;
            if (bus_phase != i2cm_pkg::PH_IDLE && pending_ticks.size() < 2)
                pending_ticks.push_back(rand_tick(0, sda_mode));
        end
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || s_axis_tvalid || line_words_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // second word is offered while busy and must be dropped
    task automatic run_command(input i2cm_pkg::t_func f, input logic [7:0] b,
                               input int sda_mode);
        t_tick_word t;
        t = rand_tick(100, sda_mode);
        t.func = f;
        t.wr_byte = b;
        pending_ticks.push_back(t);
        pending_ticks.push_back(rand_tick(100, sda_mode));
        settle_bus(sda_mode);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            i2cm_pkg::REG_LOW_TICKS:  cfg.low_ticks = val[15:0];
            i2cm_pkg::REG_HIGH_TICKS: cfg.high_ticks = val[15:0];
            i2cm_pkg::REG_HOLD_TICKS: cfg.hold_ticks = val[15:0];
            i2cm_pkg::REG_READ_ACK:   cfg.read_ack = val[0];
        endcase
    endtask

    task automatic set_timing(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] hd, input logic ack);
        settle_bus(2);
        drain();
        write_reg(i2cm_pkg::REG_LOW_TICKS, {16'($urandom), lo});
        write_reg(i2cm_pkg::REG_HIGH_TICKS, {16'($urandom), hi});
        write_reg(i2cm_pkg::REG_HOLD_TICKS, {16'($urandom), hd});
        write_reg(i2cm_pkg::REG_READ_ACK, {31'($urandom), ack});
        @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing
        run_command(i2cm_pkg::FN_START, 8'h00, 1);
        run_command(i2cm_pkg::FN_WRITE, 8'hA5, 0);
        run_command(i2cm_pkg::FN_STOP, 8'h00, 1);

        set_timing(16'd1, 16'd1, 16'd1, 1'b0);
        run_command(i2cm_pkg::FN_START, 8'h00, 1);
        run_command(i2cm_pkg::FN_WRITE, 8'hFF, 0);
        run_command(i2cm_pkg::FN_WRITE, 8'h00, 1);
        run_command(i2cm_pkg::FN_READ, 8'h00, 1);
        run_command(i2cm_pkg::FN_READ, 8'hFF, 0);
        run_command(i2cm_pkg::FN_STOP, 8'h00, 0);

        // zero times count as one tick
        set_timing(16'd0, 16'd0, 16'd0, 1'b1);
        run_command(i2cm_pkg::FN_START, 8'h00, 2);
        run_command(i2cm_pkg::FN_WRITE, 8'h5A, 2);
        run_command(i2cm_pkg::FN_READ, 8'h00, 2);
        run_command(i2cm_pkg::FN_STOP, 8'h00, 2);

        for (int p = 0; p < 4; p++) begin
            set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                       16'($urandom_range(1, 6)), 1'($urandom));
            quiet_run = (p == 1);
            repeat (200) pending_ticks.push_back(rand_tick(40, 2));
            if (p == 2) begin
                stalls_asked = stalls_asked + 1;
                while (pending_ticks.size() > 100)
                    @(negedge i_clk);
                sender_hold = 1'b1;
                while (s_axis_tvalid || line_words_due.size() != 0)
                    @(negedge i_clk);
                repeat (3) @(negedge i_clk);
                sender_hold = 1'b0;
            end
            settle_bus(2);
        end
        quiet_run = 1'b0;

        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### i2c_master_byte_engine.f
design/i2cm_pkg.sv
design/i2cm_apb_regs.sv
design/i2c_master_byte_engine.sv
tb/i2c_master_byte_engine_test.sv
